### src/pwmdps_pkg.sv
// shared widths, command codes, state encoding and helpers for the pwm setup block
package pwmdps_pkg;

  localparam int CounterWidth = 16;

  localparam int CpuHzW  = 26;
  localparam int PwmHzW  = 20;
  localparam int CfgW    = 26;
  localparam int DutyW   = 10;
  localparam int PeriodW = 16;
  localparam int CmpW    = PeriodW + 1;
  localparam int CodeW   = 3;
  localparam int FuncW   = 3;
  localparam int ValueW  = 16;

  // bit-serial divider widths
  localparam int NumW = CpuHzW + 10;             // cpu_hz * 1015
  localparam int DenW = PwmHzW + 10;             // pwm_hz * 1000
  localparam int CntW = 6;
  localparam int ProdW = PeriodW + DutyW;        // period * duty
  localparam logic [CntW-1:0] PerSteps = CntW'(NumW);
  localparam logic [CntW-1:0] CmpSteps = CntW'(ProdW);

  // wide enough to hold pwm_hz shifted by the largest ratio threshold
  localparam int RatioW = PwmHzW + CounterWidth + 8;

  localparam logic [DutyW-1:0] DutyFull = DutyW'(1000);
  localparam logic [CpuHzW-1:0] CpuHzReset = CpuHzW'(32000000);
  localparam logic [PwmHzW-1:0] PwmHzReset = PwmHzW'(1000);

  // configuration register indexes
  localparam logic CfgCpuHz = 1'b0;
  localparam logic CfgPwmHz = 1'b1;

  // commands
  localparam logic [FuncW-1:0] FuncSetWidth = 3'd0;
  localparam logic [FuncW-1:0] FuncAddWidth = 3'd1;
  localparam logic [FuncW-1:0] FuncApplyFreq = 3'd2;
  localparam logic [FuncW-1:0] FuncRun = 3'd3;
  localparam logic [FuncW-1:0] FuncStop = 3'd4;

  // clock select codes
  localparam logic [CodeW-1:0] CsDiv1 = 3'd1;
  localparam logic [CodeW-1:0] CsDiv2 = 3'd2;
  localparam logic [CodeW-1:0] CsDiv4 = 3'd3;
  localparam logic [CodeW-1:0] CsDiv8 = 3'd4;
  localparam logic [CodeW-1:0] CsDiv64 = 3'd5;
  localparam logic [CodeW-1:0] CsDiv256 = 3'd6;
  localparam logic [CodeW-1:0] CsDiv1024 = 3'd7;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EXEC    = 6'b000010,
    S_DIV_PER = 6'b000100,
    S_PER_FIN = 6'b001000,
    S_MUL     = 6'b010000,
    S_DIV_CMP = 6'b100000
  } state_t;

  // log2 of the prescale factor for a clock select code
  function automatic logic [3:0] cs_shift(input logic [CodeW-1:0] code);
    logic [3:0] sh;
    unique case (code)
      CsDiv1:    sh = 4'd0;
      CsDiv2:    sh = 4'd1;
      CsDiv4:    sh = 4'd2;
      CsDiv8:    sh = 4'd3;
      CsDiv64:   sh = 4'd6;
      CsDiv256:  sh = 4'd8;
      CsDiv1024: sh = 4'd10;
      default:   sh = 4'd0;
    endcase
    return sh;
  endfunction

  // clamp a signed 17-bit duty to 0..1000
  function automatic logic [DutyW-1:0] clamp_duty(input logic signed [16:0] d);
    logic [DutyW-1:0] r;
    if (d < 17'sd0) begin
      r = '0;
    end else if (d > 17'sd1000) begin
      r = DutyFull;
    end else begin
      r = d[DutyW-1:0];
    end
    return r;
  endfunction

endpackage

### src/pwm_duty_and_period_setup.sv
// pwm duty, prescaler and period setup with a shared bit-serial divider
//
//  channel  dir  fields (lowest bit first)
//  s_*      in   tdata: value[15:0]; tuser: func[2:0]
//  m_*      out  tdata: compare[16:0], duty_permille[26:17], period[42:27],
//                       clock_select[45:43], running[46], zero pad[47]
//  cfg_*    in   cfg_addr 0 cpu_hz, 1 pwm_hz; data in cfg_wdata low bits
//
//  one request at a time; a quotient bit per cycle in the shared divider sets the time
//  every request runs a compare divide; apply frequency adds a period divide before it
//  the next request is taken while the previous result waits in the output register
//  reset is synchronous; there is no clearing pass
//  a stalled output holds the block at the end of its compare divide
module pwm_duty_and_period_setup import pwmdps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [ValueW-1:0]    s_tdata,   // value[15:0]
  input  logic [FuncW-1:0]     s_tuser,   // func[2:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,   // compare, duty_permille, period, clock_select, running
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [CfgW-1:0]      cfg_wdata
);

  state_t state, state_next;

  logic [CpuHzW-1:0]  cpu_hz;
  logic [PwmHzW-1:0]  pwm_hz;
  logic [FuncW-1:0]   func;
  logic [ValueW-1:0]  value;

  logic [DutyW-1:0]   duty;
  logic [PeriodW-1:0] period_reg;
  logic [CodeW-1:0]   prescale_code;
  logic               enabled;

  logic [NumW-1:0]    div_num;
  logic [DenW-1:0]    div_den;
  logic [DenW-1:0]    div_rem;
  logic [CntW-1:0]    div_cnt;

  logic [CmpW-1:0]    out_compare;
  logic [DutyW-1:0]   out_duty;
  logic [PeriodW-1:0] out_period;
  logic [CodeW-1:0]   out_code;
  logic               out_running;

  logic               in_acc;
  logic               out_free;
  logic               out_load;
  logic               div_done;
  logic [DenW:0]      trial;
  logic               trial_ge;

  logic [PwmHzW-1:0]  f_eff;
  logic [RatioW-1:0]  cpu_x;
  logic [RatioW-1:0]  f_x;
  logic [CodeW-1:0]   code_sel;
  logic signed [16:0] sum_add;
  logic signed [16:0] val_ext;
  logic [NumW-1:0]    quot_shr;
  logic [PeriodW-1:0] period_sat;
  logic [ProdW-1:0]   product;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign div_done = (div_cnt == '0);
  assign out_load = (state == S_DIV_CMP) && div_done && out_free;

  assign m_tdata = {1'b0, out_running, out_code, out_period, out_duty, out_compare};

  // one restoring step
  assign trial    = {div_rem, div_num[NumW-1]};
  assign trial_ge = (trial >= {1'b0, div_den});

  // prescaler pick: ratio < 2^k  <=>  cpu_hz < pwm_hz << (CounterWidth + k)
  assign f_eff = (pwm_hz == '0) ? PwmHzW'(1) : pwm_hz;
  assign cpu_x = RatioW'(cpu_hz);
  assign f_x   = RatioW'(f_eff);

  always_comb begin
    priority if (cpu_x < (f_x << CounterWidth)) begin
      code_sel = CsDiv1;
    end else if (cpu_x < (f_x << (CounterWidth + 1))) begin
      code_sel = CsDiv2;
    end else if (cpu_x < (f_x << (CounterWidth + 2))) begin
      code_sel = CsDiv4;
    end else if (cpu_x < (f_x << (CounterWidth + 3))) begin
      code_sel = CsDiv8;
    end else if (cpu_x < (f_x << (CounterWidth + 6))) begin
      code_sel = CsDiv64;
    end else if (cpu_x < (f_x << (CounterWidth + 8))) begin
      code_sel = CsDiv256;
    end else begin
      code_sel = CsDiv1024;
    end
  end

  assign val_ext = {value[ValueW-1], value};
  assign sum_add = $signed({7'b0, duty}) + val_ext;

  // the power-of-two part of the divisor is applied after the serial divide
  assign quot_shr   = div_num >> cs_shift(prescale_code);
  assign period_sat = (|quot_shr[NumW-1:PeriodW]) ? '1 : quot_shr[PeriodW-1:0];

  assign product = ProdW'(period_reg) * ProdW'(duty);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_acc) state_next = S_EXEC;
      S_EXEC:    state_next = (func == FuncApplyFreq) ? S_DIV_PER : S_MUL;
      S_DIV_PER: if (div_done) state_next = S_PER_FIN;
      S_PER_FIN: state_next = S_MUL;
      S_MUL:     state_next = S_DIV_CMP;
      S_DIV_CMP: if (div_done && out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cpu_hz        <= CpuHzReset;
      pwm_hz        <= PwmHzReset;
      duty          <= '0;
      period_reg    <= '0;
      prescale_code <= CsDiv1;
      enabled       <= 1'b0;
      div_cnt       <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_addr)
          CfgCpuHz: cpu_hz <= cfg_wdata[CpuHzW-1:0];
          CfgPwmHz: pwm_hz <= cfg_wdata[PwmHzW-1:0];
          default:  ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (in_acc) begin
        func  <= s_tuser;
        value <= s_tdata;
      end

      unique case (state)
        S_EXEC: begin
          unique case (func)
            FuncSetWidth: duty <= clamp_duty(val_ext);
            FuncAddWidth: duty <= clamp_duty(sum_add);
            FuncApplyFreq: begin
              prescale_code <= code_sel;
              div_num <= NumW'(cpu_hz) * NumW'(1015);
              div_den <= DenW'(f_eff) * DenW'(1000);
              div_rem <= '0;
              div_cnt <= PerSteps;
            end
            FuncRun:  enabled <= 1'b1;
            FuncStop: enabled <= 1'b0;
            default:  ;
          endcase
        end
        S_DIV_PER, S_DIV_CMP: begin
          if (!div_done) begin
            div_rem <= trial_ge ? DenW'(trial - {1'b0, div_den}) : trial[DenW-1:0];
            div_num <= {div_num[NumW-2:0], trial_ge};
            div_cnt <= div_cnt - CntW'(1);
          end else if (out_load) begin
            out_compare <= (duty == DutyFull) ? (CmpW'(period_reg) + CmpW'(1))
                                              : div_num[CmpW-1:0];
            out_duty    <= duty;
            out_period  <= period_reg;
            out_code    <= prescale_code;
            out_running <= enabled;
          end
        end
        S_PER_FIN: period_reg <= period_sat;
        S_MUL: begin
          // product left-aligned so that the quotient ends in the low bits
          div_num <= {product, (NumW - ProdW)'(0)};
          div_den <= DenW'(DutyFull);
          div_rem <= '0;
          div_cnt <= CmpSteps;
        end
        default: ;
      endcase
    end
  end

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    duty <= DutyFull)
    else $error("duty above full scale");

  a_code_nonzero: assert property (@(posedge clk) disable iff (rst)
    prescale_code != '0)
    else $error("clock select code zero");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    div_cnt <= PerSteps)
    else $error("divider step count out of range");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_tready)
    else $error("second request taken while busy");

  a_full_compare: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_duty == DutyFull) |-> out_compare == (CmpW'(out_period) + CmpW'(1)))
    else $error("compare wrong at full duty");

endmodule
